// ----- sv/ecu_pkg.sv -----
package ecu_pkg;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    localparam longint unsigned LN2_Q32 = 64'd2977044472;
    localparam longint unsigned PIH_Q30 = 64'd1686629713;
    localparam longint unsigned Q32_ONE = 64'd1 << 32;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_LINEAR   = 3'd1,
        OP_IN_EXPO  = 3'd2,
        OP_OUT_EXPO = 3'd3,
        OP_IO_CIRC  = 3'd4,
        OP_IO_SINE  = 3'd5
    } op_t;

    // 2^x for x in Q32, result in Q32
    function automatic longint unsigned exp2_unit(input longint unsigned x);
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        y    = (x * LN2_Q32) >> 32;
        term = Q32_ONE;
        sum  = Q32_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * y) >> 32) / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // sin^2(pi x / 2) for x in Q32, result in Q32
    function automatic longint unsigned sin2_unit(input longint unsigned x);
        longint unsigned a;
        longint unsigned term;
        longint unsigned sum;
        a    = (x * PIH_Q30) >> 32;
        term = a;
        sum  = a;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * a) >> 30) / 64'(2 * k);
            term = ((term * a) >> 30) / 64'(2 * k + 1);
            if ((k % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        return (sum * sum) >> 28;
    endfunction

endpackage

// ----- sv/easing_curve_unit_core.sv -----
// Channel  | Ports                          | Transfer when
// -------- | ------------------------------ | ------------------------
// input    | s_valid s_ready s_op s_progress | s_valid & s_ready
// result   | m_valid m_ready m_eased        | m_valid & m_ready
//
// One item per cycle while the output is not stalled; six pipeline stages and the output register.
// The stage count is set by the square root of the circular curve, four digit stages,
// and by the ROM read, multiply, add and rounding shift of the table curves.
// aresetn (synchronous) clears all valid bits; the ROMs are constant and need no fill.
// A stalled output holds every stage; s_ready follows the output stage.
module easing_curve_unit_core
    import ecu_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_op,
    input  logic [FRAC_BITS:0]   s_progress,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_BITS:0]   m_eased
);

    localparam int F       = FRAC_BITS;
    localparam int T       = TABLE_ADDR_BITS;
    localparam int TW      = F + 1;
    localparam int ROM_N   = (2 ** T) + 1;
    localparam int IW      = T + 1;
    localparam int RW      = 32 - T;
    localparam int DW      = 35 - T;
    localparam int PW      = DW + RW;
    localparam int SQ_STEPS = F + 1;
    localparam int SQW     = 2 * SQ_STEPS;
    localparam int RMW     = F + 4;
    localparam int SQ_PER  = (SQ_STEPS + 3) / 4;

    localparam logic [TW-1:0] ONE  = TW'(1) << F;
    localparam logic [TW-1:0] HALF = TW'(1) << (F - 1);
    localparam logic [TW:0]   TWO  = (TW + 1)'(1) << (F + 1);
    localparam logic [33:0]   Q32_LIM = 34'(1) << 32;

    typedef logic [32:0] rom_t [ROM_N];

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [TW-1:0]  root;
        logic [SQW-1:0] val;
    } sq_t;

    function automatic rom_t build_rom(input logic sine);
        rom_t            r;
        longint unsigned x;
        for (int k = 0; k < ROM_N; k++) begin
            x = 64'(k) << (32 - T);
            r[k] = sine ? 33'(sin2_unit(x)) : 33'(exp2_unit(x));
        end
        return r;
    endfunction

    function automatic sq_t sq_steps(input sq_t s, input int base);
        sq_t            r;
        logic [RMW+1:0] tr;
        logic [RMW+1:0] trial;
        r = s;
        for (int i = 0; i < SQ_PER; i++) begin
            if (base + i < SQ_STEPS) begin
                tr    = {r.rem, r.val[SQW-1 -: 2]};
                r.val = r.val << 2;
                trial = (RMW + 2)'({r.root, 2'b01});
                if (tr >= trial) begin
                    tr     = tr - trial;
                    r.root = {r.root[TW-2:0], 1'b1};
                end else begin
                    r.root = {r.root[TW-2:0], 1'b0};
                end
                r.rem = tr[RMW-1:0];
            end
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom(1'b0);
    localparam rom_t SIN_ROM = build_rom(1'b1);

    logic       en;
    logic [5:0] vld_reg;
    logic       m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[4:0], s_valid};
            m_valid_reg <= vld_reg[5];
        end
    end

    // stage A: saturate, scale by ten, pick table argument and circle argument
    logic [TW-1:0] t_next;
    logic [F+4:0]  e_next;
    logic [3:0]    n_next;
    logic [F-1:0]  f_next;
    logic [TW-1:0] ru_next;
    logic [3:0]    k_next;
    logic [TW:0]   two_t;
    logic [TW-1:0] cu_next;
    logic          lo_next;
    logic          fz_next;
    logic          fo_next;

    always_comb begin
        t_next  = (s_progress > ONE) ? ONE : s_progress;
        e_next  = ({4'b0000, t_next} << 3) + ({4'b0000, t_next} << 1);
        n_next  = e_next[F+3:F];
        f_next  = e_next[F-1:0];
        lo_next = t_next < HALF;
        two_t   = {t_next, 1'b0};
        cu_next = lo_next ? two_t[TW-1:0] : TW'(TWO - two_t);
        ru_next = '0;
        k_next  = '0;
        fz_next = 1'b0;
        fo_next = 1'b0;
        unique case (op_t'(s_op))
            OP_IN_EXPO: begin
                ru_next = {1'b0, f_next};
                k_next  = 4'd10 - n_next;
                fz_next = t_next == '0;
            end
            OP_OUT_EXPO: begin
                ru_next = ONE - {1'b0, f_next};
                k_next  = 4'd1 + n_next;
                fo_next = t_next == ONE;
            end
            OP_IO_SINE: begin
                ru_next = t_next;
            end
            default: begin
                ru_next = '0;
            end
        endcase
    end

    logic [2:0]    op_a_reg, op_b_reg, op_c_reg, op_d_reg, op_e_reg, op_f_reg;
    logic [TW-1:0] t_a_reg, t_b_reg, t_c_reg, t_d_reg, t_e_reg, t_f_reg;
    logic          lo_a_reg, lo_b_reg, lo_c_reg, lo_d_reg, lo_e_reg, lo_f_reg;
    logic          fz_a_reg, fz_b_reg, fz_c_reg, fz_d_reg, fz_e_reg, fz_f_reg;
    logic          fo_a_reg, fo_b_reg, fo_c_reg, fo_d_reg, fo_e_reg, fo_f_reg;
    logic [3:0]    k_a_reg, k_b_reg, k_c_reg, k_d_reg;
    logic [TW-1:0] ru_a_reg;
    logic [TW-1:0] cu_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            op_a_reg <= s_op;      op_b_reg <= op_a_reg; op_c_reg <= op_b_reg;
            op_d_reg <= op_c_reg;  op_e_reg <= op_d_reg; op_f_reg <= op_e_reg;
            t_a_reg  <= t_next;    t_b_reg  <= t_a_reg;  t_c_reg  <= t_b_reg;
            t_d_reg  <= t_c_reg;   t_e_reg  <= t_d_reg;  t_f_reg  <= t_e_reg;
            lo_a_reg <= lo_next;   lo_b_reg <= lo_a_reg; lo_c_reg <= lo_b_reg;
            lo_d_reg <= lo_c_reg;  lo_e_reg <= lo_d_reg; lo_f_reg <= lo_e_reg;
            fz_a_reg <= fz_next;   fz_b_reg <= fz_a_reg; fz_c_reg <= fz_b_reg;
            fz_d_reg <= fz_c_reg;  fz_e_reg <= fz_d_reg; fz_f_reg <= fz_e_reg;
            fo_a_reg <= fo_next;   fo_b_reg <= fo_a_reg; fo_c_reg <= fo_b_reg;
            fo_d_reg <= fo_c_reg;  fo_e_reg <= fo_d_reg; fo_f_reg <= fo_e_reg;
            k_a_reg  <= k_next;    k_b_reg  <= k_a_reg;  k_c_reg  <= k_b_reg;
            k_d_reg  <= k_c_reg;
            ru_a_reg <= ru_next;
            cu_a_reg <= cu_next;
        end
    end

    // stage B: table read at both ends of the interval, square for the circle
    logic [32:0]   p_b;
    logic [IW-1:0] idx_b;
    logic [IW-1:0] idx1_b;
    logic          sine_a;
    logic [32:0]   s0_b_reg, s1_b_reg;
    logic [RW-1:0] rem_b_reg;
    logic [SQW-1:0] sq_b_reg;

    always_comb begin
        p_b    = {ru_a_reg, {(32 - F){1'b0}}};
        idx_b  = p_b[32 -: IW];
        idx1_b = (idx_b == IW'(ROM_N - 1)) ? idx_b : idx_b + 1'b1;
        sine_a = op_a_reg == OP_IO_SINE;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_b_reg  <= sine_a ? SIN_ROM[idx_b]  : EXP_ROM[idx_b];
            s1_b_reg  <= sine_a ? SIN_ROM[idx1_b] : EXP_ROM[idx1_b];
            rem_b_reg <= p_b[RW-1:0];
            sq_b_reg  <= SQW'(cu_a_reg * cu_a_reg);
        end
    end

    // stage C: slope times remainder
    logic          dn_next;
    logic [32:0]   diff_c;
    logic [PW-1:0] prod_c_reg;
    logic [32:0]   s0_c_reg;
    logic          dn_c_reg;

    always_comb begin
        dn_next = s1_b_reg < s0_b_reg;
        diff_c  = dn_next ? s0_b_reg - s1_b_reg : s1_b_reg - s0_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_c_reg <= diff_c[DW-1:0] * rem_b_reg;
            s0_c_reg   <= s0_b_reg;
            dn_c_reg   <= dn_next;
        end
    end

    // square root, four digit stages from C to F
    sq_t sq_init;
    sq_t sq_reg [4];

    always_comb begin
        sq_init.rem  = '0;
        sq_init.root = '0;
        sq_init.val  = (SQW'(1) << (2 * F)) - sq_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg[0] <= sq_steps(sq_init, 0);
            for (int g = 1; g < 4; g++) begin
                sq_reg[g] <= sq_steps(sq_reg[g-1], g * SQ_PER);
            end
        end
    end

    // stage D: interpolate
    logic [32:0] incr_d;
    logic [33:0] sum_d;
    logic [32:0] v_next;
    logic [32:0] v_d_reg;

    always_comb begin
        incr_d = 33'(prod_c_reg >> RW);
        sum_d  = dn_c_reg ? {1'b0, s0_c_reg} - {1'b0, incr_d}
                          : {1'b0, s0_c_reg} + {1'b0, incr_d};
        v_next = sum_d[32:0];
        if (op_c_reg == OP_IO_SINE && sum_d > Q32_LIM) begin
            v_next = Q32_LIM[32:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_d_reg <= v_next;
        end
    end

    // stage E: round to output precision by the curve's exponent
    logic [5:0]    sh_e;
    logic [33:0]   rsum_e;
    logic [TW-1:0] rv_e_reg;

    always_comb begin
        sh_e   = 6'(32 - F) + {2'b00, k_d_reg};
        rsum_e = {1'b0, v_d_reg} + (34'(1) << (sh_e - 6'd1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rv_e_reg <= TW'(rsum_e >> sh_e);
        end
    end

    // stage F: complement for ease-out
    logic [TW-1:0] rr_f_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (op_e_reg == OP_OUT_EXPO) begin
                rr_f_reg <= (rv_e_reg >= ONE) ? '0 : ONE - rv_e_reg;
            end else begin
                rr_f_reg <= rv_e_reg;
            end
        end
    end

    // output stage: select curve
    logic [TW-1:0] root_g;
    logic [TW:0]   circ_g;
    logic [TW-1:0] r_next;
    logic [TW-1:0] m_eased_reg;

    always_comb begin
        root_g = (sq_reg[3].root > ONE) ? ONE : sq_reg[3].root;
        circ_g = lo_f_reg ? ({1'b0, ONE} - {1'b0, root_g} + 1'b1) >> 1
                          : ({1'b0, ONE} + {1'b0, root_g} + 1'b1) >> 1;
        unique case (op_t'(op_f_reg))
            OP_NONE, OP_LINEAR: r_next = t_f_reg;
            OP_IN_EXPO:         r_next = fz_f_reg ? '0 : rr_f_reg;
            OP_OUT_EXPO:        r_next = fo_f_reg ? ONE : rr_f_reg;
            OP_IO_CIRC:         r_next = circ_g[TW-1:0];
            OP_IO_SINE:         r_next = rr_f_reg;
            default:            r_next = '0;
        endcase
        if (r_next > ONE) begin
            r_next = ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_eased_reg <= r_next;
        end
    end

    assign m_eased = m_eased_reg;

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_eased_reg <= ONE)
        else $error("eased value above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && vld_reg == '0)
        else $error("valid bits not cleared by reset");

endmodule
